// File: rtl/packet_reassembly_tracker_macros.svh
// Assertion macros for the reassembly tracker.
`ifndef PACKET_REASSEMBLY_TRACKER_MACROS_SVH
`define PACKET_REASSEMBLY_TRACKER_MACROS_SVH
`ifndef SYNTHESIS
`define PRT_ASSERT_IMPL(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define PRT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PRT_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define PRT_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

// File: rtl/prt_pkg.sv
package prt_pkg;
  localparam int Entries    = 16;
  localparam int MaxPackets = 64;
  localparam int IdBits     = 32;
  localparam int IdxW       = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int CntW       = $clog2(Entries + 1);
  localparam int TimeW      = 31;
  localparam int MapW       = MaxPackets;

  localparam logic [2:0] StAccepted = 3'd0;
  localparam logic [2:0] StDuplicate = 3'd1;
  localparam logic [2:0] StComplete = 3'd2;
  localparam logic [2:0] StFull = 3'd3;
  localparam logic [2:0] StReleased = 3'd4;
  localparam logic [2:0] StNotFound = 3'd5;

  localparam logic CmdAdd     = 1'b0;
  localparam logic CmdRelease = 1'b1;

  typedef struct packed {
    logic [IdBits-1:0] id;
    logic [TimeW-1:0]  last_time;
    logic [MapW-1:0]   rmap;
    logic [6:0]        count;
  } slot_t;
endpackage

// File: rtl/prt_slot_ram.sv
module prt_slot_ram
  import prt_pkg::*;
(
  input  logic           clk_i,
  input  logic           we_i,
  input  logic [IdxW-1:0] waddr_i,
  input  slot_t          wdata_i,
  input  logic [IdxW-1:0] raddr_i,
  output slot_t          rdata_o
);
  slot_t mem [Entries];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

// File: rtl/packet_reassembly_tracker.sv
// Channel   | Dir | Handshake            | Payload
// s_axis    | in  | s_axis_tvalid/tready | command, message_id, packet_number,
//           |     |                      | total_packets, now_time
// m_axis    | out | m_axis_tvalid/tready | status, packets_held
// cfg       | in  | cfg_valid/cfg_ready  | expiry_time
// One request at a time. An add runs a lookup pass over all slots, then decide, a sweep
// pass, output and idle; a release runs the lookup pass, decide, output and idle. Each
// pass waits on the registered read port of the single slot memory.
// Reset clears the valid bits and loads expiry_time with 1000; slot contents need none.
// The result waits in an output register; the next request is taken meanwhile, and a
// result still waiting there holds the following one in S_OUT.
`include "packet_reassembly_tracker_macros.svh"

module packet_reassembly_tracker
  import prt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [0] command, [32:1] message_id, [38:33] packet_number,
  // [45:39] total_packets, [76:46] now_time, [79:77] zero
  input  logic [79:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [2:0] status, [9:3] packets_held, [15:10] zero
  output logic [15:0] m_axis_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);
  typedef enum logic [2:0] {
    S_IDLE, S_LOOK, S_DECIDE, S_SWEEP, S_OUT
  } state_e;

  state_e state_q;
  logic [TimeW-1:0] expiry_q;
  logic [Entries-1:0] valid_q;
  logic cmd_q;
  logic [IdBits-1:0] id_q;
  logic [5:0] pnum_q;
  logic [6:0] total_q;
  logic [TimeW-1:0] now_q;
  logic [CntW-1:0] ptr_q;      // address issued
  logic rd_pend_q;             // read data valid this cycle
  logic [IdxW-1:0] rd_idx_q;   // address of rdata
  logic hit_q;
  logic [IdxW-1:0] hit_idx_q;
  slot_t hit_slot_q;
  logic [IdxW-1:0] tgt_q;      // slot the result refers to
  logic tgt_ok_q;
  logic [2:0] status_q;
  logic [6:0] held_q;
  logic out_v_q;
  logic [2:0] ostat_q;
  logic [6:0] oheld_q;

  logic ram_we;
  logic [IdxW-1:0] ram_waddr, ram_raddr;
  slot_t ram_wdata, ram_rdata;

  prt_slot_ram u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready     = 1'b1;
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {6'd0, oheld_q, ostat_q};
  assign ram_raddr     = ptr_q[IdxW-1:0];

  // Lowest free slot.
  logic free_ok;
  logic [IdxW-1:0] free_idx;
  always_comb begin
    free_ok  = 1'b0;
    free_idx = '0;
    for (int i = Entries - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_ok  = 1'b1;
        free_idx = IdxW'(i);
      end
    end
  end

  // Decision on the add, from the lookup result.
  logic dup_bit;
  logic [6:0] cnt_inc;
  logic [MapW-1:0] pbit;
  assign pbit    = MapW'(1) << pnum_q[$clog2(MapW > 1 ? MapW : 2)-1:0];
  assign dup_bit = (32'(pnum_q) >= MaxPackets) || ((hit_slot_q.rmap & pbit) != '0);
  assign cnt_inc = hit_slot_q.count + 7'd1;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = hit_idx_q;
    ram_wdata = hit_slot_q;
    if (state_q == S_DECIDE && !cmd_q) begin
      if (hit_q && !dup_bit) begin
        ram_we              = 1'b1;
        ram_wdata.rmap      = hit_slot_q.rmap | pbit;
        ram_wdata.count     = cnt_inc;
        ram_wdata.last_time = now_q;
      end else if (!hit_q && free_ok && 32'(pnum_q) < MaxPackets) begin
        ram_we    = 1'b1;
        ram_waddr = free_idx;
        ram_wdata.id        = id_q;
        ram_wdata.last_time = now_q;
        ram_wdata.rmap      = pbit;
        ram_wdata.count     = 7'd1;
      end
    end
  end

  // Expiry test on the slot read back during the sweep.
  logic [TimeW:0] exp_sum;
  logic stale;
  assign exp_sum = {1'b0, ram_rdata.last_time} + {1'b0, expiry_q};
  assign stale   = (exp_sum < {1'b0, now_q}) || (ram_rdata.last_time > now_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      expiry_q  <= TimeW'(1000);
      valid_q   <= '0;
      out_v_q   <= 1'b0;
      ptr_q     <= '0;
      rd_pend_q <= 1'b0;
      hit_q     <= 1'b0;
      tgt_ok_q  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        expiry_q <= cfg_data[TimeW-1:0];
      end
      // Drop the taken result; S_OUT reloads the register itself.
      if (out_v_q && m_axis_tready && state_q != S_OUT) begin
        out_v_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            cmd_q     <= s_axis_tdata[0];
            id_q      <= s_axis_tdata[32:1];
            pnum_q    <= s_axis_tdata[38:33];
            total_q   <= s_axis_tdata[45:39];
            now_q     <= s_axis_tdata[76:46];
            ptr_q     <= '0;
            rd_pend_q <= 1'b0;
            hit_q     <= 1'b0;
            state_q   <= S_LOOK;
          end
        end
        S_LOOK: begin
          // Issue reads over all slots, catch the matching one.
          rd_pend_q <= (32'(ptr_q) < Entries);
          rd_idx_q  <= ptr_q[IdxW-1:0];
          if (32'(ptr_q) < Entries) begin
            ptr_q <= ptr_q + CntW'(1);
          end
          if (rd_pend_q && valid_q[rd_idx_q] && ram_rdata.id == id_q && !hit_q) begin
            hit_q      <= 1'b1;
            hit_idx_q  <= rd_idx_q;
            hit_slot_q <= ram_rdata;
          end
          if (!rd_pend_q && 32'(ptr_q) == Entries) begin
            state_q <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          ptr_q     <= '0;
          rd_pend_q <= 1'b0;
          if (cmd_q == CmdRelease) begin
            status_q <= hit_q ? StReleased : StNotFound;
            held_q   <= hit_q ? hit_slot_q.count : 7'd0;
            if (hit_q) valid_q[hit_idx_q] <= 1'b0;
            tgt_ok_q <= 1'b0;
            state_q  <= S_OUT;
          end else begin
            state_q <= S_SWEEP;
            if (hit_q) begin
              tgt_q    <= hit_idx_q;
              tgt_ok_q <= 1'b1;
              status_q <= dup_bit ? StDuplicate
                        : (cnt_inc == total_q) ? StComplete : StAccepted;
              held_q   <= dup_bit ? hit_slot_q.count : cnt_inc;
            end else if (free_ok && 32'(pnum_q) < MaxPackets) begin
              valid_q[free_idx] <= 1'b1;
              tgt_q    <= free_idx;
              tgt_ok_q <= 1'b1;
              status_q <= (total_q == 7'd1) ? StComplete : StAccepted;
              held_q   <= 7'd1;
            end else begin
              tgt_ok_q <= 1'b0;
              status_q <= free_ok ? StDuplicate : StFull;
              held_q   <= 7'd0;
            end
          end
        end
        S_SWEEP: begin
          // Second pass: drop stale slots; the write above is already visible.
          rd_pend_q <= (32'(ptr_q) < Entries);
          rd_idx_q  <= ptr_q[IdxW-1:0];
          if (32'(ptr_q) < Entries) begin
            ptr_q <= ptr_q + CntW'(1);
          end
          if (rd_pend_q && valid_q[rd_idx_q] && stale) begin
            valid_q[rd_idx_q] <= 1'b0;
            if (tgt_ok_q && tgt_q == rd_idx_q) held_q <= 7'd0;
          end
          if (!rd_pend_q && 32'(ptr_q) == Entries) begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          // Hold until the output register is free.
          if (!out_v_q || m_axis_tready) begin
            out_v_q <= 1'b1;
            ostat_q <= status_q;
            oheld_q <= held_q;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `PRT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_v_q && !m_axis_tready, out_v_q)
  `PRT_ASSERT_IMPL(a_no_take_busy, clk_i, rst_ni, state_q != S_IDLE, !s_axis_tready)
  `PRT_ASSERT_IMPL(a_write_decide, clk_i, rst_ni, ram_we, state_q == S_DECIDE)
endmodule

// File: tb/sv/testbench.sv
module testbench;
  import prt_pkg::*;

  // Request as the sender sees it, before packing into s_axis_tdata.
  typedef struct {
    logic        cmd;
    logic [31:0] msg_id;
    logic [5:0]  pkt_num;
    logic [6:0]  pkt_total;
    logic [30:0] stamp;
  } request_t;

  typedef struct {
    logic [2:0] status;
    logic [6:0] held;
  } outcome_t;

  // An add walks the slot memory twice; allow margin on top of that.
  localparam int SettleCycles = 2 * Entries + 10;
  localparam int StallLimit   = 20000;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        cfg_valid     = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data      = '0;

  // Tracker shadow: table contents and the expiry register.
  logic [30:0] expiry_shadow;
  logic        shadow_valid [Entries];
  logic [31:0] shadow_id    [Entries];
  logic [30:0] shadow_time  [Entries];
  logic [63:0] shadow_map   [Entries];
  logic [6:0]  shadow_count [Entries];

  outcome_t    pending_outcomes[$];
  int          send_idle_pct;
  int          recv_idle_pct;
  int          mismatches;
  int          requests_sent;
  int          results_seen;
  int          quiet_cycles;

  // Random message traffic: a pool of live ids with a fixed size each.
  logic [31:0] id_pool    [20];
  logic [6:0]  total_pool [20];
  logic [30:0] clock_now;

  packet_reassembly_tracker i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Drop every slot that has gone stale or lies ahead of now (timer wrap).
  function automatic void sweep_table(input logic [30:0] now);
    longint unsigned deadline;
    for (int i = 0; i < Entries; i++) begin
      deadline = longint'(shadow_time[i]) + longint'(expiry_shadow);
      if (shadow_valid[i] && (deadline < longint'(now) || shadow_time[i] > now))
        shadow_valid[i] = 1'b0;
    end
  endfunction

  function automatic outcome_t track_request(input request_t req);
    outcome_t res;
    int       hit;
    int       spare;
    hit   = -1;
    spare = -1;
    for (int i = Entries - 1; i >= 0; i--) begin
      if (shadow_valid[i] && shadow_id[i] == req.msg_id) hit = i;
      if (!shadow_valid[i]) spare = i;
    end
    res.held = '0;
    if (req.cmd == CmdRelease) begin
      if (hit < 0) begin
        res.status = StNotFound;
      end else begin
        res.status = StReleased;
        res.held = shadow_count[hit];
        shadow_valid[hit] = 1'b0;
      end
      return res;
    end
    if (hit < 0) begin
      if (spare < 0) begin
        // No room: lookup fails first, the sweep still runs afterwards.
        sweep_table(req.stamp);
        res.status = StFull;
        return res;
      end
      hit = spare;
      shadow_valid[hit] = 1'b1;
      shadow_id[hit]    = req.msg_id;
      shadow_time[hit]  = req.stamp;
      shadow_map[hit]   = 64'd1 << req.pkt_num;
      shadow_count[hit] = 7'd1;
      res.status = (req.pkt_total == 7'd1) ? StComplete : StAccepted;
    end else if (shadow_map[hit][req.pkt_num]) begin
      // Repeat leaves the time stamp alone, so the sweep may still drop it.
      res.status = StDuplicate;
    end else begin
      shadow_map[hit][req.pkt_num] = 1'b1;
      shadow_count[hit] = shadow_count[hit] + 7'd1;
      shadow_time[hit]  = req.stamp;
      res.status = (shadow_count[hit] == req.pkt_total) ? StComplete : StAccepted;
    end
    sweep_table(req.stamp);
    if (shadow_valid[hit]) res.held = shadow_count[hit];
    return res;
  endfunction

  // Send one request; a random gap precedes it when the sender idles.
  task automatic send_request(input request_t req);
    int       gap;
    outcome_t predicted;
    gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 5) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, req.stamp, req.pkt_total, req.pkt_num, req.msg_id, req.cmd};
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = track_request(req);
    pending_outcomes.insert(pending_outcomes.size(), predicted);
    requests_sent++;
  endtask

  task automatic add_packet(input logic [31:0] id, input logic [5:0] num,
                            input logic [6:0] total, input logic [30:0] now);
    request_t req;
    req = '{CmdAdd, id, num, total, now};
    send_request(req);
  endtask

  task automatic release_message(input logic [31:0] id);
    request_t req;
    // Release ignores the remaining fields; fill them with noise.
    req = '{CmdRelease, id, 6'($urandom), 7'($urandom), 31'($urandom)};
    send_request(req);
  endtask

  // Hold off the sender until every result is back and the tracker is idle.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_expiry(input logic [31:0] value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    expiry_shadow = value[30:0];
  endtask

  task automatic test_directed();
    add_packet(32'h0000_0000, 6'd0, 7'd1, 31'd100);     // single packet completes
    add_packet(32'hFFFF_FFFF, 6'd63, 7'd64, 31'd110);
    add_packet(32'hFFFF_FFFF, 6'd63, 7'd64, 31'd111);   // repeat packet
    add_packet(32'h0000_0005, 6'd0, 7'd0, 31'd120);     // zero total never completes
    add_packet(32'h0000_0005, 6'd1, 7'd127, 31'd121);
    release_message(32'h0000_0000);
    release_message(32'h0000_0000);                     // unknown id
    add_packet(32'h0000_0007, 6'd0, 7'd2, 31'd130);
    add_packet(32'h0000_0007, 6'd1, 7'd2, 31'd131);
    add_packet(32'h0000_0007, 6'd1, 7'd2, 31'd132);
    add_packet(32'h0000_0009, 6'd3, 7'd4, 31'd2000);    // everything else expires
    add_packet(32'h0000_0005, 6'd2, 7'd4, 31'd50);      // timer wrap drops the rest
    drain_results();
    // Fill the table, then ask for one more slot.
    for (int i = 0; i < Entries; i++)
      add_packet(32'h0000_0100 + i, 6'(i), 7'd8, 31'd60);
    add_packet(32'h0000_0200, 6'd0, 7'd8, 31'd61);
    release_message(32'h0000_0103);
    add_packet(32'h0000_0200, 6'd0, 7'd8, 31'd62);
    add_packet(32'h0000_0100, 6'd1, 7'd8, 31'h7FFF_FFFF); // stale slot refreshed first
    drain_results();
  endtask

  task automatic test_expiry_extremes();
    write_expiry(32'h0000_0000);
    add_packet(32'h0000_0A00, 6'd0, 7'd3, 31'd500);
    add_packet(32'h0000_0A00, 6'd1, 7'd3, 31'd500);
    add_packet(32'h0000_0A01, 6'd0, 7'd3, 31'd501);     // first message drops
    write_expiry(32'hFFFF_FFFF);
    add_packet(32'h0000_0A02, 6'd0, 7'd3, 31'd0);
    add_packet(32'h0000_0A03, 6'd5, 7'd9, 31'h7FFF_FFFF);
    release_message(32'h0000_0A02);
    drain_results();
  endtask

  task automatic refresh_pool_entry(input int k);
    id_pool[k] = $urandom();
    case ($urandom_range(19))
      0:       total_pool[k] = 7'd0;
      1:       total_pool[k] = 7'($urandom_range(65, 127));
      2, 3:    total_pool[k] = 7'($urandom_range(9, 64));
      default: total_pool[k] = 7'($urandom_range(1, 8));
    endcase
  endtask

  task automatic test_random_messages(input int count, input int send_pct,
                                      input int recv_pct);
    int          k;
    logic [5:0]  num;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int n = 0; n < count; n++) begin
      k = $urandom_range(19);
      if ($urandom_range(99) < 4) refresh_pool_entry(k);
      // Mostly small steps forward; now and then a wrap or a long silence.
      case ($urandom_range(99))
        0:       clock_now = 31'($urandom_range(0, 50));
        1:       clock_now = clock_now + 31'($urandom_range(500, 5000));
        default: clock_now = clock_now + 31'($urandom_range(0, 40));
      endcase
      if ($urandom_range(99) < 9) begin
        release_message($urandom_range(9) == 0 ? $urandom() : id_pool[k]);
      end else begin
        if (total_pool[k] != 0 && total_pool[k] <= 64 && $urandom_range(9) != 0)
          num = 6'($urandom_range(0, total_pool[k] - 1));
        else
          num = 6'($urandom);
        add_packet(id_pool[k], num, total_pool[k], clock_now);
      end
    end
    drain_results();
  endtask

  initial begin
    mismatches    = 0;
    requests_sent = 0;
    results_seen  = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    expiry_shadow = 31'd1000;
    clock_now     = 31'($urandom);
    for (int i = 0; i < Entries; i++) shadow_valid[i] = 1'b0;
    for (int k = 0; k < 20; k++) refresh_pool_entry(k);
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_messages(400, 26, 47);
    write_expiry(32'd300);
    test_expiry_extremes();
    write_expiry(32'd300);
    test_random_messages(400, 47, 26);
    write_expiry(32'h8000_03E8);
    test_random_messages(400, 0, 0);

    drain_results();
    $display("Covered %0d requests and %0d results: single and multi packet messages,",
             requests_sent, results_seen);
    $display("repeats, releases, full table, expiry and timer wrap over several expiry values.");
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Receiver stalls at the rate of the current phase.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Compare each result against the oldest outstanding prediction.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (pending_outcomes.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result status=%0d held=%0d", $time,
                 m_axis_tdata[2:0], m_axis_tdata[9:3]);
      end else begin
        outcome_t exp_res;
        exp_res = pending_outcomes.pop_front();
        if (m_axis_tdata[2:0] !== exp_res.status) begin
          mismatches++;
          $display("%0t: status expected %0d actual %0d", $time,
                   exp_res.status, m_axis_tdata[2:0]);
        end
        if (m_axis_tdata[9:3] !== exp_res.held) begin
          mismatches++;
          $display("%0t: packets_held expected %0d actual %0d", $time,
                   exp_res.held, m_axis_tdata[9:3]);
        end
      end
    end
  end

  // Watchdog: end the run when no channel has moved for too long while work waits.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid && cfg_ready)
        || (pending_outcomes.size() == 0 && !s_axis_tvalid && !cfg_valid)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("Timeout: %0d results still outstanding", pending_outcomes.size());
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/prt_pkg.sv
rtl/prt_slot_ram.sv
rtl/packet_reassembly_tracker.sv
tb/sv/testbench.sv
